[src/kstg_pkg.sv]
// Shared constants, register codes and the quarter-wave sine generator
// for the keyed sine tone generator. No dependencies.
package kstg_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ENV_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * ENV_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_EN   = 2'd3;

  localparam logic [31:0]      RST_PHASE_STEP = 32'd68174084;
  localparam logic [ENV_W-1:0] RST_RAMP_STEP  = 15'd72;
  localparam logic [ENV_W-1:0] RST_LEVEL_MAX  = 15'd16000;
  localparam logic             RST_SOUND_EN   = 1'b1;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] SINE_PEAK  = 64'd32767;

  // Q15 sine magnitude of quarter-wave index r for a table of 2^tb entries.
  function automatic logic [ENV_W-1:0] quarter_sine(input int unsigned r,
                                                    input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(r) * TWO_PI_Q30) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    v = (sum * SINE_PEAK + (ONE_Q30 >> 1)) >> 30;
    if (v > SINE_PEAK) begin
      v = SINE_PEAK;
    end
    return v[ENV_W-1:0];
  endfunction

endpackage

[src/kstg_ifs.sv]
// Valid/ready stream interfaces for the tick requests and the sample results.
// Depends on kstg_pkg.
interface kstg_in_if
  import kstg_pkg::*;
;
  logic valid;
  logic ready;
  logic key_down;
  logic clear_envelope;

  modport source(output valid, output key_down, output clear_envelope, input ready);
  modport sink(input valid, input key_down, input clear_envelope, output ready);
endinterface

interface kstg_out_if
  import kstg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [ENV_W-1:0]           envelope_level;

  modport source(output valid, output sample, output envelope_level, input ready);
  modport sink(input valid, input sample, input envelope_level, output ready);
endinterface

[src/kstg_front.sv]
// Front end: configuration registers, tick request intake, envelope ramp and
// phase accumulator. Pushes envelope and table index into the queue. Uses kstg_pkg.
module kstg_front
  import kstg_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  kstg_in_if.sink                    in_if,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [ENV_W-1:0]           q_env,
  output logic [SINE_TABLE_BITS-1:0] q_idx
);

  logic [31:0]           phase_step_r;
  logic [ENV_W-1:0]      ramp_step_r;
  logic [ENV_W-1:0]      level_max_r;
  logic                  sound_en_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [ENV_W-1:0]      env_r;
  logic [ENV_W-1:0]      env_nxt;
  logic [ENV_W-1:0]      env_c;
  logic [ENV_W:0]        up_sum;
  logic [ENV_W-1:0]      env_up;
  logic [ENV_W-1:0]      env_dn;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    env_c  = in_if.clear_envelope ? '0 : env_r;
    up_sum = {1'b0, env_c} + {1'b0, ramp_step_r};
    env_up = (up_sum > {1'b0, level_max_r}) ? level_max_r : up_sum[ENV_W-1:0];
    env_dn = (env_c > ramp_step_r) ? env_c - ramp_step_r : '0;
    env_nxt = (in_if.key_down && sound_en_r) ? env_up : env_dn;
    phase_nxt = phase_r + PHASE_BITS'(phase_step_r);
  end

  assign q_env = env_nxt;
  assign q_idx = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= RST_PHASE_STEP;
      ramp_step_r  <= RST_RAMP_STEP;
      level_max_r  <= RST_LEVEL_MAX;
      sound_en_r   <= RST_SOUND_EN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PHASE_STEP: phase_step_r <= cfg_wdata[31:0];
        REG_RAMP_STEP:  ramp_step_r  <= cfg_wdata[ENV_W-1:0];
        REG_LEVEL_MAX:  level_max_r  <= cfg_wdata[ENV_W-1:0];
        REG_SOUND_EN:   sound_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      env_r   <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      env_r   <= env_nxt;
    end
  end

endmodule

[src/kstg_queue.sv]
// Small register queue between the front and back ends.
// Depends on nothing but its parameters.
module kstg_queue #(
  parameter int W     = 25,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

[src/kstg_back.sv]
// Back end: quarter-wave sine lookup, envelope multiply and sign restore in
// three stages ending in the output register. Uses kstg_pkg and kstg_out_if.
module kstg_back
  import kstg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  logic [ENV_W-1:0]           q_env,
  input  logic [SINE_TABLE_BITS-1:0] q_idx,
  output logic                       q_pop,
  kstg_out_if.source                 out_if
);

  localparam int ADDR_W = SINE_TABLE_BITS - 1;
  localparam int QTR    = 1 << (SINE_TABLE_BITS - 2);

  logic [ENV_W-1:0]            qtab [QTR+1];
  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-3:0]  rem;
  logic [ADDR_W-1:0]           addr;
  logic                        adv;

  logic                        v1_r;
  logic [ENV_W-1:0]            mag1_r;
  logic [ENV_W-1:0]            env1_r;
  logic                        neg1_r;
  logic                        v2_r;
  logic [PROD_W-1:0]           prod2_r;
  logic [ENV_W-1:0]            env2_r;
  logic                        neg2_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic [ENV_W-1:0]            env_out_r;
  logic [SAMPLE_W-1:0]         mag_ext;

  for (genvar i = 0; i <= QTR; i++) begin : g_qtab
    localparam logic [ENV_W-1:0] VAL = quarter_sine(i, SINE_TABLE_BITS);
    assign qtab[i] = VAL;
  end

  assign quad = q_idx[SINE_TABLE_BITS-1 -: 2];
  assign rem  = q_idx[SINE_TABLE_BITS-3:0];
  assign addr = quad[0] ? (ADDR_W'(QTR) - {1'b0, rem}) : {1'b0, rem};

  assign adv     = !out_valid_r || out_if.ready;
  assign q_pop   = adv && !q_empty;
  assign mag_ext = {1'b0, prod2_r[PROD_W-1 -: ENV_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r    <= qtab[addr];
      env1_r    <= q_env;
      neg1_r    <= quad[1];
      prod2_r   <= PROD_W'(env1_r) * PROD_W'(mag1_r);
      env2_r    <= env1_r;
      neg2_r    <= neg1_r;
      sample_r  <= neg2_r ? -$signed(mag_ext) : $signed(mag_ext);
      env_out_r <= env2_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.sample         = sample_r;
  assign out_if.envelope_level = env_out_r;

endmodule

[src/keyed_sine_tone_generator_unit.sv]
// Keyed sine tone generator: oscillator with linear attack and release.
// Instantiates kstg_front, kstg_queue and kstg_back; uses kstg_pkg and kstg_ifs.
//
// Usage:
//   in_if  : one request per sample tick (key_down, clear_envelope).
//   out_if : one result per request (sample, envelope_level), in order.
//   cfg_*  : write enable, register index and data; write only while idle.
// Throughput: one request per cycle, sustained, with out_if.ready held high.
// Path: an accepted request passes the queue register, the sine table stage,
//   the multiply stage and the output register before its result is valid.
// The front end updates envelope and phase as each request is taken and parks
// the work in a four-entry queue; the back pipeline holds while the output is
// stalled, and in_if.ready drops only when the queue is full.
// Reset: synchronous, active low; loads the register defaults, clears phase,
//   envelope, queue and all valid bits.
module keyed_sine_tone_generator_unit
  import kstg_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  kstg_in_if.sink               in_if,
  kstg_out_if.source            out_if
);

  localparam int Q_W = ENV_W + SINE_TABLE_BITS;

  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  logic [ENV_W-1:0]           push_env;
  logic [SINE_TABLE_BITS-1:0] push_idx;
  logic [Q_W-1:0]             q_rdata;

  kstg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_env     (push_env),
    .q_idx     (push_idx)
  );

  kstg_queue #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({push_env, push_idx}),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  kstg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_env   (q_rdata[Q_W-1 -: ENV_W]),
    .q_idx   (q_rdata[SINE_TABLE_BITS-1:0]),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

[src/kstg_checker.sv]
// Port-level checks for keyed_sine_tone_generator_unit and the bind that
// attaches them. Uses kstg_pkg.
module kstg_checker
  import kstg_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic [ENV_W-1:0]           out_env
);

  logic [SAMPLE_W:0] sample_mag;

  assign sample_mag = out_sample[SAMPLE_W-1] ?
                      (~{out_sample[SAMPLE_W-1], out_sample} + (SAMPLE_W+1)'(1)) :
                      {1'b0, out_sample};

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("request channel not ready right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_env))
    else $error("stalled result changed");

  a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sample_mag <= {2'b00, out_env})
    else $error("sample magnitude exceeds envelope");

endmodule

bind keyed_sine_tone_generator_unit kstg_checker u_kstg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_sample (out_if.sample),
  .out_env    (out_if.envelope_level)
);

[sim/kstg_tone_checker.sv]
`timescale 1ns / 100ps
// Tone checker: watches the tick requests, config writes and sample results,
// predicts envelope and sine output per request and compares them in order.
// Depends on kstg_pkg.
module kstg_tone_checker
  import kstg_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       tick_valid,
  input  logic                       tick_ready,
  input  logic                       key_down,
  input  logic                       clear_envelope,
  input  logic                       smp_valid,
  input  logic                       smp_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [ENV_W-1:0]           envelope_level,
  output int                         mismatches,
  output int                         pending
);

  localparam int LUT_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER  = LUT_SIZE / 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ENV_W-1:0]           level;
  } tone_t;

  logic signed [SAMPLE_W-1:0] sine_lut [LUT_SIZE];
  tone_t                      expected_tones [$];

  logic [31:0]           step_reg;
  logic [PHASE_BITS-1:0] phase;
  logic [ENV_W-1:0]      ramp_reg;
  logic [ENV_W-1:0]      ceiling_reg;
  logic [ENV_W-1:0]      env;
  logic                  sound_reg;

  function automatic logic [SAMPLE_W-1:0] taylor_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] mag;
    for (int i = 0; i < LUT_SIZE; i++) begin
      if ((i / QUARTER) % 2 == 1) begin
        mag = taylor_sine(QUARTER - i % QUARTER);
      end else begin
        mag = taylor_sine(i % QUARTER);
      end
      sine_lut[i] = ((i / QUARTER) >= 2) ? -mag : mag;
    end
  end

  function automatic tone_t predict_tone(input logic key, input logic clr);
    tone_t                      t;
    logic [ENV_W:0]             raised;
    logic signed [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0]        mag;
    logic [2*ENV_W:0]           prod;
    if (clr) begin
      env = '0;
    end
    if (key && sound_reg) begin
      raised = {1'b0, env} + {1'b0, ramp_reg};
      env = (raised > {1'b0, ceiling_reg}) ? ceiling_reg : raised[ENV_W-1:0];
    end else begin
      env = (env > ramp_reg) ? env - ramp_reg : '0;
    end
    s    = sine_lut[phase[PHASE_BITS-1 -: SINE_TABLE_BITS]];
    mag  = (s < 0) ? -s : s;
    prod = env * mag;
    t.level  = env;
    t.sample = (s < 0) ? SAMPLE_W'(-(prod >> 15)) : SAMPLE_W'(prod >> 15);
    phase = phase + PHASE_BITS'(step_reg);
    return t;
  endfunction

  always @(posedge clk) begin
    tone_t want;
    if (!rst_n) begin
      step_reg    = RST_PHASE_STEP;
      ramp_reg    = RST_RAMP_STEP;
      ceiling_reg = RST_LEVEL_MAX;
      sound_reg   = RST_SOUND_EN;
      phase       = '0;
      env         = '0;
      mismatches  = 0;
      expected_tones.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PHASE_STEP: step_reg    = cfg_wdata[31:0];
          REG_RAMP_STEP:  ramp_reg    = cfg_wdata[ENV_W-1:0];
          REG_LEVEL_MAX:  ceiling_reg = cfg_wdata[ENV_W-1:0];
          REG_SOUND_EN:   sound_reg   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (tick_valid && tick_ready) begin
        expected_tones.push_back(predict_tone(key_down, clear_envelope));
      end
      if (smp_valid && smp_ready) begin
        if (expected_tones.size() == 0) begin
          $error("unexpected result: sample %0d envelope_level %0d", sample, envelope_level);
          mismatches = mismatches + 1;
        end else begin
          want = expected_tones.pop_front();
          if (sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, sample);
            mismatches = mismatches + 1;
          end
          if (envelope_level !== want.level) begin
            $error("envelope_level: expected %0d, got %0d", want.level, envelope_level);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    pending <= expected_tones.size();
  end

endmodule

[sim/keyed_sine_tone_generator_unit_test.sv]
`timescale 1ns / 100ps
// Top of the tone generator test: clock, reset, tick requests, result stalls and verdict.
// Depends on kstg_pkg, kstg_ifs, keyed_sine_tone_generator_unit and kstg_tone_checker.
module keyed_sine_tone_generator_unit_test;
  import kstg_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  quiet;
  int                    mismatches;
  int                    pending;

  kstg_in_if  in_ch ();
  kstg_out_if out_ch ();

  keyed_sine_tone_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  kstg_tone_checker tone_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .tick_valid    (in_ch.valid),
    .tick_ready    (in_ch.ready),
    .key_down      (in_ch.key_down),
    .clear_envelope(in_ch.clear_envelope),
    .smp_valid     (out_ch.valid),
    .smp_ready     (out_ch.ready),
    .sample        (out_ch.sample),
    .envelope_level(out_ch.envelope_level),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic key, input logic clr);
    in_ch.valid          <= 1'b1;
    in_ch.key_down       <= key;
    in_ch.clear_envelope <= clr;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] step, input logic [ENV_W-1:0] ramp,
                                input logic [ENV_W-1:0] ceiling, input logic sound);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_RAMP_STEP, CFG_DATA_W'(ramp));
    write_reg(REG_LEVEL_MAX, CFG_DATA_W'(ceiling));
    write_reg(REG_SOUND_EN, CFG_DATA_W'(sound));
    cfg_we <= 1'b0;
  endtask

  task automatic play_phrases(input int count);
    int   left;
    int   run;
    logic key;
    left = count;
    while (left > 0) begin
      key = 1'($urandom_range(0, 1));
      run = $urandom_range(1, 60);
      for (int i = 0; i < run && left > 0; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
        end else begin
          send_tick(key, $urandom_range(0, 15) == 0);
        end
        left--;
      end
    end
  endtask

  initial begin
    logic [31:0]      step;
    logic [ENV_W-1:0] ramp;
    logic [ENV_W-1:0] ceiling;
    logic             sound;
    rst_n                <= 1'b0;
    quiet                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_PHASE_STEP;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.key_down       <= 1'b0;
    in_ch.clear_envelope <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    repeat (3) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    drain;

    apply_settings(32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF, 1'b1);
    repeat (2) send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    drain;

    // lower the ceiling under the held envelope
    apply_settings(32'h4000_0000, 15'h7FFF, 15'd100, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0);
    drain;

    // zero ramp holds the envelope
    apply_settings(32'h0000_0000, 15'd0, 15'h7FFF, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    drain;

    apply_settings(32'h0100_0000, 15'd5000, 15'h7FFF, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0);
    drain;

    // mute forces release while the key is held
    apply_settings(32'h0100_0000, 15'd5000, 15'h7FFF, 1'b0);
    repeat (2) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain;

    apply_settings(32'h0123_4567, 15'd300, 15'd0, 1'b1);
    repeat (2) send_tick(1'b1, 1'b0);
    drain;

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        step    = RST_PHASE_STEP;
        ramp    = RST_RAMP_STEP;
        ceiling = RST_LEVEL_MAX;
        sound   = RST_SOUND_EN;
      end else begin
        case ($urandom_range(0, 5))
          0:       step = '0;
          1:       step = '1;
          2:       step = $urandom_range(1, 1 << 24);
          default: step = $urandom;
        endcase
        case ($urandom_range(0, 7))
          0:       ramp = '0;
          1:       ramp = '1;
          default: ramp = ENV_W'($urandom_range(1, 1500));
        endcase
        case ($urandom_range(0, 7))
          0:       ceiling = '0;
          1:       ceiling = '1;
          default: ceiling = ENV_W'($urandom_range(500, 32767));
        endcase
        sound = $urandom_range(0, 4) != 0;
      end
      if (p == 7) begin
        quiet <= 1'b1;
      end
      apply_settings(step, ramp, ceiling, sound);
      play_phrases(180);
      drain;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
src/kstg_pkg.sv
src/kstg_ifs.sv
src/kstg_front.sv
src/kstg_queue.sv
src/kstg_back.sv
src/keyed_sine_tone_generator_unit.sv
src/kstg_checker.sv
sim/kstg_tone_checker.sv
sim/keyed_sine_tone_generator_unit_test.sv
